// ===== rtl/core/gcv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcv_pkg: shared types and constants of the GLB container validator
// Result codes, byte kinds, fault codes and the queue word layout.
// ----------------------------------------------------------------------------
package gcv_pkg;

	localparam logic [31:0] GLB_MAGIC        = 32'h4654_6C67;
	localparam logic [31:0] JSON_TYPE        = 32'h4E4F_534A;
	localparam logic [31:0] GLB_VERSION      = 32'd2;
	localparam logic [31:0] HEADER_BYTES     = 32'd12;
	localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;
	localparam logic [2:0]  CHUNK_LEN_LAST   = 3'd3;
	localparam logic [2:0]  CHUNK_HDR_LAST   = 3'd7;
	localparam int unsigned QUEUE_DEPTH      = 4;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_MAGIC    = 3'd2,
		ST_VERSION  = 3'd3,
		ST_LENGTH   = 3'd4,
		ST_OVERRUN  = 3'd5,
		ST_DUP_JSON = 3'd6,
		ST_NO_JSON  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		HF_NONE    = 2'd0,
		HF_MAGIC   = 2'd1,
		HF_VERSION = 2'd2
	} header_fault_t;

	typedef enum logic [1:0] {
		CF_NONE    = 2'd0,
		CF_OVERRUN = 2'd1,
		CF_DUP     = 2'd2
	} chunk_fault_t;

	// where a byte sits in the container
	typedef enum logic [2:0] {
		KIND_HEADER,      // header byte with no check attached
		KIND_MAGIC_END,   // last byte of magic
		KIND_VERSION_END, // last byte of version
		KIND_TOTAL_END,   // last byte of declared length
		KIND_CHUNK        // anything after the 12-byte header
	} byte_kind_t;

	// one queue word: byte plus what the front worked out about it
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		byte_kind_t  kind;
		logic [32:0] off;   // position + 1, 2^32 once the count saturates
	} queue_entry_t;

endpackage

// ===== rtl/core/gcv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcv_front: byte intake and classification
// Counts bytes, tags each with its header role and next offset.
// ----------------------------------------------------------------------------
module gcv_front import gcv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	input  logic         byte_valid,
	output logic         byte_ready,
	input  logic         queue_full,
	output logic         push,
	output queue_entry_t push_entry
);

	logic [31:0] pos_q;
	logic [32:0] off;

	assign byte_ready = !queue_full;
	assign push       = byte_valid && byte_ready;
	assign off        = {1'b0, pos_q} + 33'd1;

	always_comb begin
		push_entry.data = data_byte;
		push_entry.last = last_byte;
		push_entry.off  = off;
		push_entry.kind = KIND_CHUNK;
		if (pos_q < HEADER_BYTES) begin
			case (pos_q[3:0])
				4'd3:    push_entry.kind = KIND_MAGIC_END;
				4'd7:    push_entry.kind = KIND_VERSION_END;
				4'd11:   push_entry.kind = KIND_TOTAL_END;
				default: push_entry.kind = KIND_HEADER;
			endcase
		end
	end

	// saturating position, back to zero after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (last_byte) begin
				pos_q <= '0;
			end else if (pos_q != COUNT_MAX) begin
				pos_q <= off[31:0];
			end
		end
	end

endmodule

// ===== rtl/core/gcv_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcv_queue: short word queue between intake and parser
// Circular buffer with occupancy count; head word read directly.
// ----------------------------------------------------------------------------
module gcv_queue import gcv_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  queue_entry_t push_entry,
	output logic         full,
	input  logic         pop,
	output queue_entry_t pop_entry,
	output logic         not_empty
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	queue_entry_t       slot_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/gcv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcv_back: container parser and result register
// Walks header and chunk headers, skips bodies, reports on final byte.
// ----------------------------------------------------------------------------
module gcv_back import gcv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         not_empty,
	input  queue_entry_t pop_entry,
	output logic         pop,
	output logic         result_valid,
	input  logic         result_ready,
	output logic [2:0]   status,
	output logic [31:0]  json_offset,
	output logic [31:0]  json_length
);

	logic [31:0]   word_q, word_n;
	logic [31:0]   declared_q, declared_n;
	header_fault_t hf_q, hf_n;
	logic          in_body_q, in_body_n;
	logic [2:0]    chi_q, chi_n;
	logic [31:0]   cur_len_q, cur_len_n;
	logic [31:0]   remain_q, remain_n;
	chunk_fault_t  cf_q, cf_n;
	logic          json_seen_q, json_seen_n;
	logic [31:0]   found_off_q, found_off_n;
	logic [31:0]   found_len_q, found_len_n;

	logic          result_valid_q;
	status_t       status_q;
	logic [31:0]   json_offset_q;
	logic [31:0]   json_length_q;

	logic [33:0]   chunk_end;
	logic          overrun;
	logic [31:0]   count_after;
	status_t       verdict;

	assign pop = not_empty && (!pop_entry.last || !result_valid_q || result_ready);

	// end of chunk body against the declared total
	assign chunk_end = {2'b00, cur_len_n} + {1'b0, pop_entry.off};
	assign overrun   = (cur_len_n != '0) && (chunk_end > {2'b00, declared_q});

	always_comb begin
		word_n      = {pop_entry.data, word_q[31:8]};
		declared_n  = declared_q;
		hf_n        = hf_q;
		in_body_n   = in_body_q;
		chi_n       = chi_q;
		cur_len_n   = cur_len_q;
		remain_n    = remain_q;
		cf_n        = cf_q;
		json_seen_n = json_seen_q;
		found_off_n = found_off_q;
		found_len_n = found_len_q;
		case (pop_entry.kind)
			KIND_MAGIC_END: begin
				if (word_n != GLB_MAGIC) hf_n = HF_MAGIC;
			end
			KIND_VERSION_END: begin
				if (hf_q == HF_NONE && word_n != GLB_VERSION) hf_n = HF_VERSION;
			end
			KIND_TOTAL_END: begin
				declared_n = word_n;
			end
			KIND_CHUNK: begin
				if (cf_q != CF_NONE) begin
					cf_n = cf_q;
				end else if (in_body_q) begin
					remain_n = remain_q - 32'd1;
					if (remain_n == '0) in_body_n = 1'b0;
				end else begin
					if (chi_q == CHUNK_LEN_LAST) cur_len_n = word_n;
					if (chi_q == CHUNK_HDR_LAST) begin
						chi_n = '0;
						if (overrun) begin
							cf_n = CF_OVERRUN;
						end else if (word_n == JSON_TYPE && json_seen_q) begin
							cf_n = CF_DUP;
						end else begin
							if (word_n == JSON_TYPE) begin
								json_seen_n = 1'b1;
								found_off_n = pop_entry.off[31:0];
								found_len_n = cur_len_n;
							end
							if (cur_len_n != '0) begin
								in_body_n = 1'b1;
								remain_n  = cur_len_n;
							end
						end
					end else begin
						chi_n = chi_q + 3'd1;
					end
				end
			end
			default: begin
				hf_n = hf_q;
			end
		endcase
	end

	assign count_after = pop_entry.off[32] ? COUNT_MAX : pop_entry.off[31:0];

	always_comb begin
		if (count_after < HEADER_BYTES)                              verdict = ST_SHORT;
		else if (hf_n == HF_MAGIC)                                   verdict = ST_MAGIC;
		else if (hf_n == HF_VERSION)                                 verdict = ST_VERSION;
		else if (count_after == COUNT_MAX || declared_n != count_after) verdict = ST_LENGTH;
		else if (cf_n == CF_OVERRUN)                                 verdict = ST_OVERRUN;
		else if (cf_n == CF_DUP)                                     verdict = ST_DUP_JSON;
		else if (!json_seen_n)                                       verdict = ST_NO_JSON;
		else                                                         verdict = ST_OK;
	end

	// parse state, cleared after every final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q      <= '0;
			declared_q  <= '0;
			hf_q        <= HF_NONE;
			in_body_q   <= 1'b0;
			chi_q       <= '0;
			cur_len_q   <= '0;
			remain_q    <= '0;
			cf_q        <= CF_NONE;
			json_seen_q <= 1'b0;
			found_off_q <= '0;
			found_len_q <= '0;
		end else if (pop) begin
			if (pop_entry.last) begin
				word_q      <= '0;
				declared_q  <= '0;
				hf_q        <= HF_NONE;
				in_body_q   <= 1'b0;
				chi_q       <= '0;
				cur_len_q   <= '0;
				remain_q    <= '0;
				cf_q        <= CF_NONE;
				json_seen_q <= 1'b0;
				found_off_q <= '0;
				found_len_q <= '0;
			end else begin
				word_q      <= word_n;
				declared_q  <= declared_n;
				hf_q        <= hf_n;
				in_body_q   <= in_body_n;
				chi_q       <= chi_n;
				cur_len_q   <= cur_len_n;
				remain_q    <= remain_n;
				cf_q        <= cf_n;
				json_seen_q <= json_seen_n;
				found_off_q <= found_off_n;
				found_len_q <= found_len_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pop && pop_entry.last) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_entry.last) begin
			status_q      <= verdict;
			json_offset_q <= (verdict == ST_OK) ? found_off_n : '0;
			json_length_q <= (verdict == ST_OK) ? found_len_n : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign json_offset  = json_offset_q;
	assign json_length  = json_length_q;

	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && pop_entry.last |=> result_valid_q)
		else $error("final byte did not load a result");

	a_body_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> remain_q != '0)
		else $error("chunk body open with nothing left");

	a_body_not_mid_header: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> chi_q == '0)
		else $error("chunk body entered mid chunk header");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |-> !(pop && pop_entry.last))
		else $error("pending result overwritten");

endmodule

// ===== rtl/core/glb_container_chunk_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glb_container_chunk_validator: binary glTF container check
// Byte-wide GLB header and chunk walker giving one verdict per container.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | word
//  ---------+-----------+-----------------------------+-------------------------------
//  byte     | in        | byte_valid / byte_ready     | data_byte, last_byte
//  result   | out       | result_valid / result_ready | status, json_offset, json_length
//
//  One byte per cycle while the intake queue is not full; the parser step is a
//  34-bit add and compare for the chunk end, plus counter updates.
//  On the final byte: it is written into the intake queue, and the parser,
//  which is combinational, loads the result register from the queue head once
//  the byte reaches it and no earlier result is waiting for result_ready.
//  Reset clears the byte count, queue pointers, parse state and result valid.
//  A stalled result holds the parser only at the next final byte; the queue
//  (QUEUE_DEPTH words) keeps bytes flowing in until it fills.
// ----------------------------------------------------------------------------
module glb_container_chunk_validator import gcv_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  status,
	output logic [31:0] json_offset,
	output logic [31:0] json_length
);

	logic         push;
	queue_entry_t push_entry;
	logic         queue_full;
	logic         pop;
	queue_entry_t pop_entry;
	logic         not_empty;

	// intake: counts bytes and tags header positions
	gcv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples intake from a stalled result
	gcv_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.not_empty  (not_empty)
	);

	// parser and result register
	gcv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (not_empty),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.json_offset  (json_offset),
		.json_length  (json_length)
	);

endmodule

// ===== tb/sv/tb_glb_container_chunk_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glb_container_chunk_validator: self-checking bench for the GLB container check
// Streams clean and damaged binary glTF containers byte by byte, predicts each
// verdict with a local parser and compares every result word field by field.
// ----------------------------------------------------------------------------
module tb_glb_container_chunk_validator;
	import gcv_pkg::*;

	localparam logic [31:0] BIN_TYPE = 32'h004E_4942;

	// damage applied to a built container
	typedef enum int {
		DMG_NONE,
		DMG_MAGIC,
		DMG_VERSION,
		DMG_BOTH,     // magic and version both wrong, magic must win
		DMG_LENGTH,
		DMG_OVERRUN
	} damage_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} stream_word_t;

	typedef struct {
		status_t     st;
		logic [31:0] off;
		logic [31:0] len;
	} verdict_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        byte_valid   = 1'b0;
	logic        byte_ready;
	logic [7:0]  data_byte    = 8'h00;
	logic        last_byte    = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  status;
	logic [31:0] json_offset;
	logic [31:0] json_length;

	glb_container_chunk_validator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.json_offset  (json_offset),
		.json_length  (json_length)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Verdict predictor: a private copy of the container parse state
	// ------------------------------------------------------------------------
	logic [31:0]   seen_bytes;   // saturating byte count
	logic [31:0]   shift_word;   // last four bytes, little-endian
	logic [31:0]   decl_total;
	logic [31:0]   chunk_len;
	logic [31:0]   body_left;
	logic [31:0]   json_off;
	logic [31:0]   json_len;
	header_fault_t hdr_fault;
	chunk_fault_t  chk_fault;
	logic          in_body;
	logic          json_seen;
	logic [2:0]    chdr_idx;     // byte index within a chunk header
	verdict_t      verdicts_due[$];
	int            mismatch_count;

	task automatic clear_parse();
		seen_bytes = '0;
		shift_word = '0;
		decl_total = '0;
		chunk_len  = '0;
		body_left  = '0;
		json_off   = '0;
		json_len   = '0;
		hdr_fault  = HF_NONE;
		chk_fault  = CF_NONE;
		in_body    = 1'b0;
		json_seen  = 1'b0;
		chdr_idx   = '0;
	endtask

	// Advance the parse by one byte; on the final byte queue the verdict.
	task automatic parse_byte(input logic [7:0] b, input logic fin);
		logic [31:0] pos;
		logic [32:0] off;
		logic [32:0] room;
		verdict_t    v;
		pos = seen_bytes;
		shift_word = {b, shift_word[31:8]};
		if (pos < HEADER_BYTES) begin
			if (pos == 32'd3 && shift_word != GLB_MAGIC)
				hdr_fault = HF_MAGIC;
			else if (pos == 32'd7 && hdr_fault == HF_NONE && shift_word != GLB_VERSION)
				hdr_fault = HF_VERSION;
			else if (pos == 32'd11)
				decl_total = shift_word;
		end else if (chk_fault == CF_NONE) begin
			if (in_body) begin
				body_left = body_left - 32'd1;
				if (body_left == 32'd0)
					in_body = 1'b0;
			end else begin
				if (chdr_idx == CHUNK_LEN_LAST)
					chunk_len = shift_word;
				if (chdr_idx == CHUNK_HDR_LAST) begin
					chdr_idx = 3'd0;
					// body starts after this byte; room is judged against the declared total
					off  = {1'b0, pos} + 33'd1;
					room = ({1'b0, decl_total} >= off) ? {1'b0, decl_total} - off : 33'd0;
					if ({1'b0, chunk_len} > room) begin
						chk_fault = CF_OVERRUN;
					end else if (shift_word == JSON_TYPE && json_seen) begin
						chk_fault = CF_DUP;
					end else begin
						if (shift_word == JSON_TYPE) begin
							json_seen = 1'b1;
							json_off  = off[31:0];
							json_len  = chunk_len;
						end
						if (chunk_len != 32'd0) begin
							in_body   = 1'b1;
							body_left = chunk_len;
						end
					end
				end else begin
					chdr_idx = chdr_idx + 3'd1;
				end
			end
		end
		if (seen_bytes != COUNT_MAX)
			seen_bytes = seen_bytes + 32'd1;
		if (fin) begin
			if (seen_bytes < HEADER_BYTES)
				v.st = ST_SHORT;
			else if (hdr_fault == HF_MAGIC)
				v.st = ST_MAGIC;
			else if (hdr_fault == HF_VERSION)
				v.st = ST_VERSION;
			else if (seen_bytes == COUNT_MAX || decl_total != seen_bytes)
				v.st = ST_LENGTH;
			else if (chk_fault == CF_OVERRUN)
				v.st = ST_OVERRUN;
			else if (chk_fault == CF_DUP)
				v.st = ST_DUP_JSON;
			else if (!json_seen)
				v.st = ST_NO_JSON;
			else
				v.st = ST_OK;
			v.off = (v.st == ST_OK) ? json_off : 32'd0;
			v.len = (v.st == ST_OK) ? json_len : 32'd0;
			verdicts_due.push_back(v);
			clear_parse();
		end
	endtask

	// ------------------------------------------------------------------------
	// Container builder: assembles one container, then queues its bytes
	// ------------------------------------------------------------------------
	stream_word_t bytes_to_send[$];
	logic [7:0]   glb_buf[$];
	int           bytes_queued;

	task automatic put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			glb_buf.push_back(w[8*i +: 8]);
	endtask

	task automatic put_chunk(input logic [31:0] ctype, input int body);
		put_word(32'(body));
		put_word(ctype);
		repeat (body) glb_buf.push_back(8'($urandom));
	endtask

	function automatic logic [31:0] pick_type();
		case ($urandom_range(0, 3))
			0, 1:    return BIN_TYPE;
			2:       return JSON_TYPE ^ (32'd1 << $urandom_range(0, 31)); // near miss on JSON
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_container();
		stream_word_t w;
		for (int i = 0; i < glb_buf.size(); i++) begin
			w.data = glb_buf[i];
			w.last = (i == glb_buf.size() - 1);
			bytes_to_send.push_back(w);
		end
		bytes_queued = bytes_queued + glb_buf.size();
		glb_buf.delete();
	endtask

	// Header, chunks (bins, JSONs, bins), optional overrun chunk, trailing bytes.
	task automatic make_glb(input int pre_bin, input int jsons, input int post_bin,
	                        input int trail, input int max_body, input damage_t dmg);
		int          body;
		logic [31:0] total;
		logic [31:0] ver;
		logic [31:0] clen;
		glb_buf.delete();
		put_word(GLB_MAGIC);
		put_word(GLB_VERSION);
		put_word(32'd0);
		repeat (pre_bin) put_chunk(pick_type(), $urandom_range(0, max_body));
		repeat (jsons) put_chunk(JSON_TYPE, $urandom_range(0, max_body));
		repeat (post_bin) put_chunk(pick_type(), $urandom_range(0, max_body));
		if (dmg == DMG_OVERRUN) begin
			// room for this chunk is its real body plus the trailing bytes
			body = $urandom_range(0, 4);
			clen = ($urandom_range(0, 3) == 0) ? COUNT_MAX :
			       32'(body + trail + $urandom_range(1, 40));
			put_word(clen);
			put_word(($urandom_range(0, 1) == 1) ? JSON_TYPE : pick_type());
			repeat (body) glb_buf.push_back(8'($urandom));
		end
		repeat (trail) glb_buf.push_back(8'($urandom));
		total = 32'(glb_buf.size());
		// a wrong length also rides along with other damage now and then
		if (dmg == DMG_LENGTH || (dmg != DMG_NONE && $urandom_range(0, 2) == 0)) begin
			case ($urandom_range(0, 3))
				0:       total = COUNT_MAX;
				1:       total = total + 32'($urandom_range(1, 20));
				2:       total = total - 32'($urandom_range(1, 12));
				default: total = $urandom;
			endcase
		end
		for (int i = 0; i < 4; i++)
			glb_buf[8 + i] = total[8*i +: 8];
		if (dmg == DMG_MAGIC || dmg == DMG_BOTH) begin
			body = $urandom_range(0, 31);
			glb_buf[body / 8] = glb_buf[body / 8] ^ (8'h01 << (body % 8));
		end
		if (dmg == DMG_VERSION || dmg == DMG_BOTH) begin
			case ($urandom_range(0, 3))
				0:       ver = 32'd0;
				1:       ver = 32'd3;
				2:       ver = COUNT_MAX;
				default: ver = $urandom;
			endcase
			if (ver == GLB_VERSION)
				ver = 32'd1;
			for (int i = 0; i < 4; i++)
				glb_buf[4 + i] = ver[8*i +: 8];
		end
		queue_container();
	endtask

	// Arbitrary bytes of a given count, optionally opening with a plausible header.
	task automatic make_loose(input int n, input bit header_like);
		glb_buf.delete();
		if (header_like) begin
			put_word(GLB_MAGIC);
			put_word(GLB_VERSION);
			put_word($urandom);
		end
		while (glb_buf.size() < n)
			glb_buf.push_back(8'($urandom));
		while (glb_buf.size() > n)
			void'(glb_buf.pop_back());
		queue_container();
	endtask

	// ------------------------------------------------------------------------
	// Byte driver: bursts of random length with random gaps between them
	// ------------------------------------------------------------------------
	int burst_left;
	int gap_left;

	always @(posedge clk) begin
		stream_word_t w;
		logic         nxt_valid;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			data_byte  <= 8'h00;
			last_byte  <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
			clear_parse();
		end else begin
			if (byte_valid && byte_ready)
				parse_byte(data_byte, last_byte);
			// only move on once the word on offer has gone
			if (!byte_valid || byte_ready) begin
				nxt_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
				end else if (bytes_to_send.size() > 0) begin
					w = bytes_to_send.pop_front();
					nxt_valid = 1'b1;
					data_byte <= w.data;
					last_byte <= w.last;
					burst_left = burst_left - 1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				byte_valid <= nxt_valid;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor and receiver stall pattern
	// ------------------------------------------------------------------------
	int results_taken;
	int rx_tick;
	int hold_left;
	bit hold_done;

	always @(posedge clk) begin
		verdict_t v;
		logic     nxt_ready;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (verdicts_due.size() == 0) begin
					$error("result word with no verdict pending: status %0d", status);
					mismatch_count++;
				end else begin
					v = verdicts_due.pop_front();
					if (status !== v.st) begin
						$error("status: expected %0d, got %0d", v.st, status);
						mismatch_count++;
					end
					if (json_offset !== v.off) begin
						$error("json_offset: expected %0d, got %0d", v.off, json_offset);
						mismatch_count++;
					end
					if (json_length !== v.len) begin
						$error("json_length: expected %0d, got %0d", v.len, json_length);
						mismatch_count++;
					end
				end
				results_taken++;
			end
			rx_tick++;
			// one long hold-off so the intake queue fills and byte_ready drops
			if (!hold_done && results_taken == 10) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				nxt_ready = 1'b0;
			end else begin
				case ((rx_tick / 64) % 4)
					0:       nxt_ready = 1'b1;
					1:       nxt_ready = 1'($urandom_range(0, 1));
					2:       nxt_ready = (rx_tick % 4 == 0);
					default: nxt_ready = ($urandom_range(0, 4) != 0);
				endcase
			end
			result_ready <= nxt_ready;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int pick;
		int trail;
		int body_max;

		// directed: aims for one of each verdict plus the awkward corners
		make_loose(1, 1'b0);                    // single byte, marked last
		make_loose(11, 1'b1);                   // header one byte short
		make_glb(0, 1, 0, 0, 4, DMG_BOTH);      // magic reported ahead of version
		make_glb(0, 1, 0, 0, 4, DMG_VERSION);
		make_glb(0, 1, 0, 0, 4, DMG_LENGTH);
		make_glb(0, 0, 0, 0, 0, DMG_NONE);      // header only, no chunk at all
		make_glb(0, 1, 0, 0, 0, DMG_NONE);      // empty JSON chunk
		make_glb(1, 1, 1, 7, 8, DMG_NONE);      // seven trailing bytes ignored
		make_glb(0, 1, 0, 0, 4, DMG_OVERRUN);
		make_glb(0, 2, 0, 0, 4, DMG_NONE);      // second JSON chunk
		make_glb(2, 0, 0, 3, 4, DMG_NONE);      // bins only

		// random: mostly well-formed containers with random content
		while (bytes_queued < 900) begin
			pick     = $urandom_range(0, 99);
			body_max = ($urandom_range(0, 9) == 0) ? 64 : 10;
			trail    = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 7);
			if (pick < 55)
				make_glb($urandom_range(0, 2), 1, $urandom_range(0, 2), trail, body_max,
				         DMG_NONE);
			else if (pick < 60)
				make_glb($urandom_range(0, 3), 0, 0, trail, body_max, DMG_NONE);
			else if (pick < 65)
				make_glb($urandom_range(0, 1), 2, $urandom_range(0, 1), trail, body_max,
				         DMG_NONE);
			else if (pick < 69)
				make_glb($urandom_range(0, 1), 1, 0, trail, body_max, DMG_MAGIC);
			else if (pick < 73)
				make_glb($urandom_range(0, 1), 1, 0, trail, body_max, DMG_VERSION);
			else if (pick < 75)
				make_glb(0, 1, 0, trail, body_max, DMG_BOTH);
			else if (pick < 81)
				make_glb($urandom_range(0, 1), 1, $urandom_range(0, 1), trail, body_max,
				         DMG_LENGTH);
			else if (pick < 88)
				make_glb($urandom_range(0, 1), $urandom_range(0, 1), 0, trail, body_max,
				         DMG_OVERRUN);
			else if (pick < 93)
				make_loose($urandom_range(1, 11), $urandom_range(0, 1));
			else
				make_loose($urandom_range(12, 60), $urandom_range(0, 1));
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// drain: everything sent and every verdict seen, then a short settle
		do
			@(posedge clk);
		while (bytes_to_send.size() != 0 || byte_valid || verdicts_due.size() != 0);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("glb_container_chunk_validator regression: pass");
		else
			$display("glb_container_chunk_validator regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("glb_container_chunk_validator regression: fail");
		$finish;
	end

endmodule
